>>> hdl/rbp_pkg.sv
// Package for the ring buffer packetizer: sizes, item kinds, register indexes
// and the memory request type shared by the controller and the ring memory.
// No dependencies.
package rbp_pkg;

   localparam int BUFFER_DEPTH = 2048;
   localparam int PACKET_MAX   = 64;
   localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
   localparam int PTR_W        = ADDR_W + 1;
   localparam int CNT_W        = $clog2(PACKET_MAX + 1);
   localparam int FI_W         = 8;
   localparam int MP_W         = 7;
   localparam int BYTE_W       = 8;

   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_TICK  = 2'd1,
      KIND_DONE  = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic {
      CSR_FRAME_INTERVAL = 1'b0,
      CSR_MAX_PACKET     = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [BYTE_W-1:0] wdata;
      logic              re;
      logic [ADDR_W-1:0] raddr;
   } ring_req_type;

endpackage

>>> hdl/rbp_ring.sv
// Byte ring store: one write port and one read port with registered read data.
// Depends on rbp_pkg.
module rbp_ring
   import rbp_pkg::*;
(
   input  logic              clock,
   input  ring_req_type      ring_req,
   output logic [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0] mem [BUFFER_DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ring_req.we) begin
         mem[ring_req.waddr] <= ring_req.wdata;
      end
      if (ring_req.re) begin
         rd_data_ff <= mem[ring_req.raddr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/rbp_ctrl.sv
// Packetizer controller: ring indexes, frame tick pacing, packet sizing, ring
// write and read issue into the ring memory and the two-entry result queue.
// Depends on rbp_pkg.
module rbp_ctrl
   import rbp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_kind,
   input  logic [BYTE_W-1:0] req_data_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [BYTE_W-1:0] rsp_packet_byte,
   output logic              rsp_packet_end,
   input  logic [FI_W-1:0]   frame_interval,
   input  logic [MP_W-1:0]   max_packet,
   output ring_req_type      ring_req,
   input  logic [BYTE_W-1:0] rd_data
);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SIZE   = 3'b010,
      S_STREAM = 3'b100
   } state_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
   } entry_type;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0]  rd_ff, rd_in;
   logic [PTR_W-1:0]  pend_ff, pend_in;
   logic              busy_ff, busy_in;
   logic [FI_W-1:0]   tick_ff, tick_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              infl_ff, infl_in;
   logic              infl_end_ff, infl_end_in;
   entry_type         q_ff [2];
   logic              q_head_ff, q_head_in;
   logic              q_tail_ff, q_tail_in;
   logic [1:0]        q_cnt_ff, q_cnt_in;

   kind_type          kind;
   logic              accept;
   logic              issue;
   logic              push;
   logic              pop;
   logic [PTR_W-1:0]  rd_norm;
   logic [CNT_W-1:0]  lim;

   assign kind      = kind_type'(req_kind);
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign push      = infl_ff;
   assign pop       = rsp_valid && rsp_ready;
   assign issue     = (state_ff == S_STREAM) && (cnt_ff != '0) &&
                      ({1'b0, q_cnt_ff} + {2'b00, infl_ff} < 3'd2 + {2'b00, pop});

   assign rd_norm = (rd_ff >= PTR_W'(BUFFER_DEPTH)) ? '0 : rd_ff;

   always_comb begin
      lim = CNT_W'(max_packet);
      if (max_packet == '0) begin
         lim = CNT_W'(1);
      end else if (max_packet > MP_W'(PACKET_MAX)) begin
         lim = CNT_W'(PACKET_MAX);
      end
   end

   always_comb begin
      state_in    = state_ff;
      wr_in       = wr_ff;
      rd_in       = rd_ff;
      pend_in     = pend_ff;
      busy_in     = busy_ff;
      tick_in     = tick_ff;
      cnt_in      = cnt_ff;
      infl_in     = issue;
      infl_end_in = (cnt_ff == CNT_W'(1));
      ring_req    = '0;
      ring_req.waddr = wr_ff;
      ring_req.wdata = req_data_byte;
      ring_req.raddr = rd_ff[ADDR_W-1:0];
      ring_req.re    = issue;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (kind)
                  KIND_WRITE: begin
                     ring_req.we = 1'b1;
                     wr_in = (wr_ff == ADDR_W'(BUFFER_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
                  end
                  KIND_TICK: begin
                     if (tick_ff == frame_interval) begin
                        tick_in = '0;
                        if (!busy_ff) begin
                           rd_in = rd_norm;
                           if (rd_norm != {1'b0, wr_ff}) begin
                              pend_in  = (rd_norm > {1'b0, wr_ff}) ?
                                         PTR_W'(BUFFER_DEPTH) - rd_norm :
                                         {1'b0, wr_ff} - rd_norm;
                              busy_in  = 1'b1;
                              state_in = S_SIZE;
                           end
                        end
                     end else begin
                        tick_in = tick_ff + 1'b1;
                     end
                  end
                  KIND_DONE: begin
                     if (busy_ff) begin
                        if (pend_ff == '0) begin
                           busy_in = 1'b0;
                        end else begin
                           state_in = S_SIZE;
                        end
                     end
                  end
                  KIND_NONE: begin
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SIZE: begin
            cnt_in   = (pend_ff < PTR_W'(lim)) ? pend_ff[CNT_W-1:0] : lim;
            state_in = S_STREAM;
         end
         S_STREAM: begin
            if (issue) begin
               cnt_in  = cnt_ff - 1'b1;
               pend_in = pend_ff - 1'b1;
               rd_in   = rd_ff + 1'b1;
               if (cnt_ff == CNT_W'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      q_head_in = pop ? ~q_head_ff : q_head_ff;
      q_tail_in = push ? ~q_tail_ff : q_tail_ff;
      q_cnt_in  = q_cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   assign rsp_valid       = (q_cnt_ff != '0);
   assign rsp_packet_byte = q_ff[q_head_ff].data;
   assign rsp_packet_end  = q_ff[q_head_ff].last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         wr_ff     <= '0;
         rd_ff     <= '0;
         pend_ff   <= '0;
         busy_ff   <= 1'b0;
         tick_ff   <= '0;
         cnt_ff    <= '0;
         infl_ff   <= 1'b0;
         q_head_ff <= 1'b0;
         q_tail_ff <= 1'b0;
         q_cnt_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         wr_ff     <= wr_in;
         rd_ff     <= rd_in;
         pend_ff   <= pend_in;
         busy_ff   <= busy_in;
         tick_ff   <= tick_in;
         cnt_ff    <= cnt_in;
         infl_ff   <= infl_in;
         q_head_ff <= q_head_in;
         q_tail_ff <= q_tail_in;
         q_cnt_ff  <= q_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      infl_end_ff <= infl_end_in;
      if (push) begin
         q_ff[q_tail_ff] <= '{data: rd_data, last: infl_end_ff};
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (q_cnt_ff != 2'd2 || pop))
      else $error("result queue overflow");

   a_no_write_in_packet: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !ring_req.we)
      else $error("ring write while a packet is in progress");

   a_stream_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STREAM) |-> (busy_ff && pend_ff >= PTR_W'(cnt_ff)))
      else $error("packet streams beyond the pending run");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      issue |-> (rd_ff < PTR_W'(BUFFER_DEPTH)))
      else $error("ring read past the end");

   a_end_closes: assert property (@(posedge clock) disable iff (reset)
      (issue && cnt_ff == CNT_W'(1)) |=> (state_ff == S_IDLE && infl_end_ff))
      else $error("last byte of packet not flagged");
`endif

endmodule

>>> hdl/ring_buffer_packetizer.sv
// A frame tick or transfer done that starts a packet passes the sizing state, then
// the stream state, which reads bytes through the registered ring read port into the
// result queue, one per cycle while the queue has room. Writes, ignored items and
// idle ticks are taken one per cycle; a packet holds off the input until all its bytes are read.
// Reset: synchronous, active high; clears indexes, counters and sender state and
// loads frame_interval 15 and max_packet 64; ring contents are left as they are.
module ring_buffer_packetizer
   import rbp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_kind,
   input  logic [BYTE_W-1:0] req_data_byte,
   input  logic              req_message_last,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [BYTE_W-1:0] rsp_packet_byte,
   output logic              rsp_packet_end,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [FI_W-1:0]   csr_wdata
);

   logic [FI_W-1:0]   frame_interval_ff;
   logic [MP_W-1:0]   max_packet_ff;
   ring_req_type      ring_req;
   logic [BYTE_W-1:0] rd_data;
   csr_index_type     csr_sel;
   logic              unused_last;

   assign csr_sel     = csr_index_type'(csr_index);
   assign unused_last = req_message_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_interval_ff <= FI_W'(15);
         max_packet_ff     <= MP_W'(64);
      end else if (csr_we) begin
         unique case (csr_sel)
            CSR_FRAME_INTERVAL: frame_interval_ff <= csr_wdata;
            CSR_MAX_PACKET:     max_packet_ff     <= csr_wdata[MP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   rbp_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_packet_byte (rsp_packet_byte),
      .rsp_packet_end  (rsp_packet_end),
      .frame_interval  (frame_interval_ff),
      .max_packet      (max_packet_ff),
      .ring_req        (ring_req),
      .rd_data         (rd_data)
   );

   rbp_ring u_ring (
      .clock    (clock),
      .ring_req (ring_req),
      .rd_data  (rd_data)
   );

endmodule
